[hw/rtl/gnfc_pkg.sv]
// ----------------------------------------------------------------------------
// gnfc_pkg
// Shared types and constants of the receiver frame checker.
// ----------------------------------------------------------------------------
package gnfc_pkg;

  localparam int unsigned LengthWidthDefault = 10;
  localparam int unsigned OutLenWidth = 10;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] Sync1 = 8'hB5;
  localparam logic [7:0] Sync2 = 8'h62;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar = 8'h2A;
  localparam logic [7:0] ChComma = 8'h2C;

  localparam logic [9:0] LimitReset = 10'd120;
  localparam logic [7:0] ClassReset = 8'h01;
  localparam logic [7:0] IdReset = 8'h3C;
  localparam logic [23:0] TypeReset = 24'h474741;

  typedef enum logic [1:0] {
    RegLimit = 2'd0,
    RegClass = 2'd1,
    RegId    = 2'd2,
    RegType  = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    VerdictOk     = 3'd0,
    VerdictNoCk   = 3'd1,
    VerdictFields = 3'd2,
    VerdictBadCk  = 3'd3,
    VerdictHeader = 3'd4
  } verdict_e;

  // front-end classification of one byte
  typedef enum logic [2:0] {
    KindText   = 3'd0,
    KindDollar = 3'd1,
    KindSync   = 3'd2,
    KindOpen   = 3'd3,
    KindHeader = 3'd4,
    KindBody   = 3'd5,
    KindReject = 3'd6
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic                   frame_kind;
    logic [2:0]             verdict;
    logic                   type_matches;
    logic [OutLenWidth-1:0] frame_length;
    logic [15:0]            received_check;
    logic [15:0]            computed_check;
  } result_t;

  function automatic logic [4:0] hex_of(input logic [7:0] b);
    logic [4:0] r;
    r = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b0, b[3:0]};
    else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
      r = {1'b0, b[3:0] + 4'd9};
    return r;
  endfunction

endpackage

[hw/rtl/gnfc_front.sv]
// ----------------------------------------------------------------------------
// gnfc_front
// Tracks framing mode and tags each byte but a sync lead-in for the back end.
// ----------------------------------------------------------------------------
module gnfc_front import gnfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [9:0] limit_i,
  input  logic [7:0] class_i,
  input  logic [7:0] id_i,
  input  logic       valid_i,
  input  logic [7:0] byte_i,
  output logic       ready_o,
  output logic       push_o,
  output item_t      item_o,
  input  logic       full_i
);

  typedef enum logic [2:0] {
    StText   = 3'b001,
    StHeader = 3'b010,
    StBody   = 3'b100
  } st_e;

  st_e         st_q, st_d;
  logic        sync_q, sync_d;
  logic [1:0]  hcnt_q, hcnt_d;
  logic [23:0] hdr_q, hdr_d;
  logic [15:0] left_q, left_d;
  logic [15:0] len;
  logic        fire;

  assign ready_o = !full_i;
  assign fire = valid_i && ready_o;
  assign len = {byte_i, hdr_q[23:16]};

  always_comb begin
    st_d = st_q;
    sync_d = sync_q;
    hcnt_d = hcnt_q;
    hdr_d = hdr_q;
    left_d = left_q;
    push_o = 1'b0;
    item_o.kind = KindText;
    item_o.data = byte_i;
    if (fire) begin
      case (st_q)
        StHeader: begin
          push_o = 1'b1;
          item_o.kind = KindHeader;
          case (hcnt_q)
            2'd0: hdr_d[7:0] = byte_i;
            2'd1: hdr_d[15:8] = byte_i;
            2'd2: hdr_d[23:16] = byte_i;
            default: ;
          endcase
          hcnt_d = hcnt_q + 2'd1;
          if (hcnt_q == 2'd3) begin
            if (hdr_q[7:0] != class_i || hdr_q[15:8] != id_i || len == 16'd0 ||
                len > {6'd0, limit_i}) begin
              st_d = StText;
              item_o.kind = KindReject;
            end else begin
              st_d = StBody;
              left_d = len + 16'd2;
            end
          end
        end
        StBody: begin
          push_o = 1'b1;
          item_o.kind = KindBody;
          left_d = left_q - 16'd1;
          if (left_q == 16'd1) st_d = StText;
        end
        default: begin
          if (sync_q) begin
            sync_d = 1'b0;
            push_o = 1'b1;
            if (byte_i == Sync2) begin
              item_o.kind = KindOpen;
              st_d = StHeader;
              hcnt_d = 2'd0;
              hdr_d = '0;
            end
          end else if (byte_i == ChDollar) begin
            push_o = 1'b1;
            item_o.kind = KindDollar;
          end else if (byte_i == Sync1) begin
            sync_d = 1'b1;
          end else begin
            push_o = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StText;
      sync_q <= 1'b0;
      hcnt_q <= '0;
      hdr_q <= '0;
      left_q <= '0;
    end else begin
      st_q <= st_d;
      sync_q <= sync_d;
      hcnt_q <= hcnt_d;
      hdr_q <= hdr_d;
      left_q <= left_d;
    end
  end

  a_sync_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sync_q |-> st_q == StText) else $error("sync pending outside text");
  a_body_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StBody |-> left_q != 16'd0) else $error("body without bytes left");
  a_push_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> fire) else $error("push without transaction");

endmodule

[hw/rtl/gnfc_queue.sv]
// ----------------------------------------------------------------------------
// gnfc_queue
// Small FIFO of tagged bytes between front and back end.
// ----------------------------------------------------------------------------
module gnfc_queue import gnfc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  output logic  valid_o,
  output item_t item_o,
  input  logic  pop_i
);

  item_t      mem_q [QueueDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o = cnt_q == 2'(QueueDepth);
  assign valid_o = cnt_q != 2'd0;
  assign item_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

[hw/rtl/gnfc_back.sv]
// ----------------------------------------------------------------------------
// gnfc_back
// Runs sentence and message checksums and emits one result per frame.
// ----------------------------------------------------------------------------
module gnfc_back import gnfc_pkg::*; #(
  parameter int unsigned LengthWidth = LengthWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [23:0] type_i,
  input  logic        valid_i,
  input  item_t       item_i,
  output logic        pop_o,
  output logic        res_valid_o,
  output result_t     res_o,
  input  logic        res_ready_i
);

  localparam logic [LengthWidth-1:0] LenMax = '1;

  logic [LengthWidth-1:0] tcnt_q, tcnt_d;
  logic [7:0]  xor_q, xor_d, hexv_q, hexv_d;
  logic        star_q, star_d, hstop_q, hstop_d;
  logic [1:0]  hcnt_q, hcnt_d, ff_q, ff_d;
  logic [2:0]  tm_q, tm_d;
  logic [1:0]  bh_q, bh_d;
  logic [15:0] blen_q, blen_d, bleft_q, bleft_d;
  logic [15:0] fs_q, fs_d, last_q, last_d;
  logic        ov_q;
  result_t     out_q, r;
  logic        emit;
  logic [7:0]  b, sa, sb;
  logic [4:0]  hx;
  logic [2:0]  tv;
  logic [OutLenWidth-1:0] tlen, blen_cap;

  assign b = item_i.data;
  assign pop_o = valid_i && (!ov_q || res_ready_i);
  assign res_valid_o = ov_q;
  assign res_o = out_q;
  assign hx = hex_of(b);
  assign sa = fs_q[15:8] + b;
  assign sb = fs_q[7:0] + sa;

  always_comb begin
    if (LengthWidth > OutLenWidth && tcnt_q > LengthWidth'(1023)) tlen = '1;
    else tlen = OutLenWidth'(tcnt_q);
    if (blen_d > 16'd1023) blen_cap = '1;
    else blen_cap = blen_d[OutLenWidth-1:0];
    if (!star_q || hcnt_q == 2'd0) tv = VerdictNoCk;
    else if (!ff_q[1]) tv = VerdictFields;
    else if (hexv_q != xor_q) tv = VerdictBadCk;
    else tv = VerdictOk;
  end

  always_comb begin
    tcnt_d = tcnt_q; xor_d = xor_q; hexv_d = hexv_q; star_d = star_q;
    hstop_d = hstop_q; hcnt_d = hcnt_q; ff_d = ff_q; tm_d = tm_q;
    bh_d = bh_q; blen_d = blen_q; bleft_d = bleft_q; fs_d = fs_q;
    last_d = last_q;
    emit = 1'b0;
    r = '0;
    r.frame_kind = 1'b0;
    r.verdict = tv;
    r.type_matches = tm_q == 3'b111;
    r.frame_length = tlen;
    r.received_check = {8'd0, hexv_q};
    r.computed_check = {8'd0, xor_q};
    if (pop_o) begin
      if (item_i.kind == KindDollar || item_i.kind == KindOpen) begin
        emit = tcnt_q != '0;
        tcnt_d = '0; xor_d = '0; hexv_d = '0; star_d = 1'b0; hstop_d = 1'b0;
        hcnt_d = '0; ff_d = '0; tm_d = '0;
      end
      case (item_i.kind)
        KindOpen: begin
          bh_d = '0; fs_d = '0; last_d = '0; blen_d = '0;
        end
        KindHeader, KindReject: begin
          fs_d = {sa, sb};
          bh_d = bh_q + 2'd1;
          if (bh_q == 2'd2) blen_d = {8'd0, b};
          if (bh_q == 2'd3) begin
            blen_d = {b, blen_q[7:0]};
            bleft_d = blen_d + 16'd2;
            if (item_i.kind == KindReject) begin
              emit = 1'b1;
              r = '0;
              r.frame_kind = 1'b1;
              r.verdict = VerdictHeader;
              r.frame_length = blen_cap;
            end
          end
        end
        KindBody: begin
          if (bleft_q > 16'd2) fs_d = {sa, sb};
          else last_d = {last_q[7:0], b};
          bleft_d = bleft_q - 16'd1;
          if (bleft_q == 16'd1) begin
            emit = 1'b1;
            r = '0;
            r.frame_kind = 1'b1;
            r.verdict = (last_d == fs_q) ? VerdictOk : VerdictBadCk;
            r.frame_length = blen_q > 16'd1023 ? '1 : blen_q[OutLenWidth-1:0];
            r.received_check = last_d;
            r.computed_check = fs_q;
          end
        end
        default: ;
      endcase
      if (item_i.kind == KindText || item_i.kind == KindDollar) begin
        if (tcnt_d < LenMax) tcnt_d = tcnt_d + LengthWidth'(1);
        if (!star_d) begin
          if (b == ChStar) star_d = 1'b1;
          else begin
            if (b != ChDollar) xor_d = xor_d ^ b;
            if (ff_d[0]) ff_d[1] = 1'b1;
            else if (b == ChComma) ff_d[0] = 1'b1;
            else if (tcnt_q == LengthWidth'(3) && item_i.kind == KindText)
              tm_d[0] = b == type_i[23:16];
            else if (tcnt_q == LengthWidth'(4) && item_i.kind == KindText)
              tm_d[1] = b == type_i[15:8];
            else if (tcnt_q == LengthWidth'(5) && item_i.kind == KindText)
              tm_d[2] = b == type_i[7:0];
          end
        end else if (!hstop_d && hcnt_d < 2'd2) begin
          if (hx[4]) hstop_d = 1'b1;
          else begin
            hexv_d = {hexv_d[3:0], hx[3:0]};
            hcnt_d = hcnt_d + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcnt_q <= '0; xor_q <= '0; hexv_q <= '0; star_q <= 1'b0; hstop_q <= 1'b0;
      hcnt_q <= '0; ff_q <= '0; tm_q <= '0; bh_q <= '0; blen_q <= '0;
      bleft_q <= '0; fs_q <= '0; last_q <= '0; ov_q <= 1'b0;
    end else begin
      tcnt_q <= tcnt_d; xor_q <= xor_d; hexv_q <= hexv_d; star_q <= star_d;
      hstop_q <= hstop_d; hcnt_q <= hcnt_d; ff_q <= ff_d; tm_q <= tm_d;
      bh_q <= bh_d; blen_q <= blen_d; bleft_q <= bleft_d; fs_q <= fs_d;
      last_q <= last_d;
      if (emit) ov_q <= 1'b1;
      else if (res_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) out_q <= r;
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !res_ready_i |=> ov_q) else $error("result lost");
  a_no_pop_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !res_ready_i |-> !pop_o) else $error("pop while result stalled");
  a_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> out_q.verdict <= VerdictHeader) else $error("bad verdict code");

endmodule

[hw/rtl/gnss_nmea_ubx_frame_checker.sv]
// ----------------------------------------------------------------------------
// gnss_nmea_ubx_frame_checker
// Checks NMEA text sentences and UBX binary messages in a receiver byte stream.
// ----------------------------------------------------------------------------
// channel   dir  tdata / fields
// s_axis    in   [7:0] rx_byte
// m_axis    out  frame_kind, verdict, type_matches, frame_length, checks
// cfg       in   cfg_addr_i register index, cfg_data_i value
// One byte per cycle sustained while no result stalls. A two-entry queue
// decouples the mode tracker from the checksum back end; an output
// register holds a stalled result. Reset is asynchronous and needs no
// clearing pass.
module gnss_nmea_ubx_frame_checker import gnfc_pkg::*; #(
  parameter int unsigned LengthWidth = LengthWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] frame_kind [3:1] verdict [4] type_matches [14:5] frame_length
  // [30:15] received_check [46:31] computed_check, zero padded
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [23:0] cfg_data_i
);

  logic [9:0]  limit_q;
  logic [7:0]  class_q, id_q;
  logic [23:0] type_q;
  logic        push, full, qvalid, pop;
  item_t       fitem, qitem;
  result_t     res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
      class_q <= ClassReset;
      id_q <= IdReset;
      type_q <= TypeReset;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_addr_i))
        RegLimit: limit_q <= cfg_data_i[9:0];
        RegClass: class_q <= cfg_data_i[7:0];
        RegId:    id_q <= cfg_data_i[7:0];
        RegType:  type_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  gnfc_front u_front (
    .clk_i, .rst_ni, .limit_i(limit_q), .class_i(class_q), .id_i(id_q),
    .valid_i(s_axis_tvalid), .byte_i(s_axis_tdata), .ready_o(s_axis_tready),
    .push_o(push), .item_o(fitem), .full_i(full)
  );

  gnfc_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .item_i(fitem), .full_o(full),
    .valid_o(qvalid), .item_o(qitem), .pop_i(pop)
  );

  gnfc_back #(.LengthWidth(LengthWidth)) u_back (
    .clk_i, .rst_ni, .type_i(type_q), .valid_i(qvalid), .item_i(qitem),
    .pop_o(pop), .res_valid_o(m_axis_tvalid), .res_o(res),
    .res_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {1'b0, res.computed_check, res.received_check,
                         res.frame_length, res.type_matches, res.verdict,
                         res.frame_kind};

endmodule

[dv/gnss_nmea_ubx_frame_checker_tb.sv]
// ----------------------------------------------------------------------------
// gnss_nmea_ubx_frame_checker_tb
// Drives text sentences, binary messages and noise bytes through the frame
// checker under random stalls, predicts every verdict and compares results.
// ----------------------------------------------------------------------------
module gnss_nmea_ubx_frame_checker_tb;
  import gnfc_pkg::*;

  localparam int unsigned LenMax = 1023;
  localparam int unsigned CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_addr_i = '0;
  logic [23:0] cfg_data_i = '0;

  gnss_nmea_ubx_frame_checker u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [9:0]  lim_q;
  logic [7:0]  cls_q, id_q;
  logic [23:0] stype_q;
  logic [1:0]  mode_q;
  logic        sync_q, star_q, hstop_q;
  logic [9:0]  tcnt_q;
  logic [10:0] bcnt_q, btgt_q;
  logic [7:0]  txor_q, hval_q;
  logic [1:0]  hcnt_q;
  logic [1:0]  fld_q;
  logic [2:0]  tmatch_q;
  logic [31:0] hdr_q;
  logic [15:0] fsum_q, last2_q;

  result_t     frames_expected[$];
  logic [7:0]  bytes_pending[$];
  bit          quiet;
  int          errors, n_bytes, n_frames, cycles;

  task automatic text_reset();
    tcnt_q = '0; txor_q = '0; star_q = 0; hcnt_q = '0;
    hstop_q = 0; hval_q = '0; fld_q = '0; tmatch_q = '0;
  endtask

  function automatic int hex_digit(logic [7:0] b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "A" && b <= "F") return b - "A" + 10;
    if (b >= "a" && b <= "f") return b - "a" + 10;
    return -1;
  endfunction

  task automatic text_add(logic [7:0] b);
    int unsigned pos;
    int d;
    pos = tcnt_q;
    if (tcnt_q != 10'h3FF) tcnt_q++;
    if (!star_q) begin
      if (b == ChStar) begin
        star_q = 1;
        return;
      end
      if (b != ChDollar) txor_q ^= b;
      if (fld_q[0]) fld_q[1] = 1;
      else if (b == ChComma) fld_q[0] = 1;
      else if (pos >= 3 && pos <= 5) begin
        if (b == stype_q[8*(5-pos) +: 8]) tmatch_q[pos-3] = 1;
      end
    end else if (!hstop_q && hcnt_q < 2) begin
      d = hex_digit(b);
      if (d < 0) hstop_q = 1;
      else begin
        hval_q = {hval_q[3:0], d[3:0]};
        hcnt_q++;
      end
    end
  endtask

  task automatic text_close();
    result_t r;
    if (tcnt_q == 0) return;
    r = '0;
    if (!star_q || hcnt_q == 0) r.verdict = VerdictNoCk;
    else if (!fld_q[1]) r.verdict = VerdictFields;
    else if (hval_q != txor_q) r.verdict = VerdictBadCk;
    else r.verdict = VerdictOk;
    r.type_matches = (tmatch_q == 3'b111);
    r.frame_length = tcnt_q;
    r.received_check = {8'h00, hval_q};
    r.computed_check = {8'h00, txor_q};
    frames_expected = {frames_expected, r};
  endtask

  task automatic fletcher(logic [7:0] b);
    logic [7:0] a;
    a = fsum_q[15:8] + b;
    fsum_q = {a, fsum_q[7:0] + a};
  endtask

  task automatic predict_byte(logic [7:0] b);
    result_t r;
    logic [15:0] len;
    r = '0;
    if (mode_q == 1) begin
      hdr_q[8*bcnt_q[1:0] +: 8] = b;
      fletcher(b);
      bcnt_q++;
      if (bcnt_q >= 4) begin
        len = hdr_q[31:16];
        bcnt_q = 0;
        if (hdr_q[7:0] != cls_q || hdr_q[15:8] != id_q || len == 0 || len > lim_q) begin
          r.frame_kind = 1;
          r.verdict = VerdictHeader;
          r.frame_length = (len > LenMax) ? 10'(LenMax) : len[9:0];
          frames_expected = {frames_expected, r};
          mode_q = 0;
          text_reset();
        end else begin
          btgt_q = len[10:0] + 11'd2;
          mode_q = 2;
        end
      end
    end else if (mode_q == 2) begin
      if (bcnt_q + 2 < btgt_q) fletcher(b);
      else last2_q = {last2_q[7:0], b};
      bcnt_q++;
      if (bcnt_q >= btgt_q) begin
        r.frame_kind = 1;
        r.verdict = (last2_q == fsum_q) ? VerdictOk : VerdictBadCk;
        r.frame_length = 10'(btgt_q - 11'd2);
        r.received_check = last2_q;
        r.computed_check = fsum_q;
        frames_expected = {frames_expected, r};
        mode_q = 0;
        bcnt_q = 0;
        text_reset();
      end
    end else if (sync_q) begin
      sync_q = 0;
      if (b == Sync2) begin
        text_close();
        text_reset();
        mode_q = 1;
        bcnt_q = 0; hdr_q = 0; btgt_q = 0; fsum_q = 0; last2_q = 0;
      end else text_add(b);
    end else if (b == ChDollar) begin
      text_close();
      text_reset();
      text_add(b);
    end else if (b == Sync1) sync_q = 1;
    else text_add(b);
  endtask

  // stimulus builders
  int n_items;

  task automatic put_byte(logic [7:0] b);
    bytes_pending = {bytes_pending, b};
    n_items++;
  endtask

  task automatic put_sentence(bit good_ck, int nflds, bit match);
    logic [7:0] body[$];
    logic [7:0] x;
    int nf;
    string hx;
    body = {"G", "P"};
    if (match) body = {body, stype_q[23:16], stype_q[15:8], stype_q[7:0]};
    else for (int i = 0; i < 3; i++) body = {body, 8'($urandom_range(65, 90))};
    nf = $urandom_range(0, 3);
    for (int i = 0; i < nflds; i++) begin
      body = {body, ChComma};
      repeat ($urandom_range(0, 6)) body = {body, 8'($urandom_range(48, 57))};
    end
    x = 0;
    foreach (body[i]) x ^= body[i];
    if (!good_ck) x ^= 8'($urandom_range(1, 255));
    put_byte(ChDollar);
    foreach (body[i]) put_byte(body[i]);
    if (nf != 0) begin
      put_byte(ChStar);
      hx = $urandom_range(0, 1) ? $sformatf("%02X", x) : $sformatf("%02x", x);
      put_byte(hx[0]);
      if ($urandom_range(0, 9) != 0) put_byte(hx[1]);
      if ($urandom_range(0, 1)) put_byte(8'h0D);
    end
  endtask

  task automatic put_binary(logic [7:0] c, logic [7:0] i, int len, bit good_ck);
    logic [7:0] a, s, b;
    logic [7:0] hdr[4];
    hdr = '{c, i, 8'(len), 8'(len >> 8)};
    a = 0; s = 0;
    put_byte(Sync1);
    put_byte(Sync2);
    foreach (hdr[k]) begin
      put_byte(hdr[k]);
      a += hdr[k]; s += a;
    end
    if (len >= 1 && len <= lim_q && c == cls_q && i == id_q) begin
      for (int k = 0; k < len; k++) begin
        b = 8'($urandom);
        put_byte(b);
        a += b; s += a;
      end
      if (!good_ck) a ^= 8'($urandom_range(1, 255));
      put_byte(a);
      put_byte(s);
    end
  endtask

  task automatic random_block(int count);
    int sel;
    n_items = 0;
    while (n_items < count) begin
      sel = $urandom_range(0, 9);
      if (sel < 4) put_sentence($urandom_range(0, 3) != 0, $urandom_range(0, 4),
                                $urandom_range(0, 1));
      else if (sel < 7)
        put_binary(cls_q, id_q, $urandom_range(1, (lim_q > 12) ? 12 : lim_q),
                   $urandom_range(0, 3) != 0);
      else if (sel == 7)
        put_binary($urandom_range(0, 1) ? cls_q : 8'($urandom),
                   $urandom_range(0, 1) ? id_q : 8'($urandom),
                   $urandom_range(0, 65535), 1);
      else
        repeat ($urandom_range(1, 6))
          put_byte($urandom_range(0, 3) == 0 ? Sync1 : 8'($urandom));
    end
  endtask

  // driver: predicts at acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_byte(s_axis_tdata);
        n_bytes++;
      end
      if ((!s_axis_tvalid || s_axis_tready) && bytes_pending.size() != 0 &&
          (quiet || $urandom_range(0, 99) >= 30)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= bytes_pending.pop_front();
      end else if (s_axis_tready) s_axis_tvalid <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni) begin
      cycles++;
      if (m_axis_tvalid && m_axis_tready) begin
        got.frame_kind = m_axis_tdata[0];
        got.verdict = m_axis_tdata[3:1];
        got.type_matches = m_axis_tdata[4];
        got.frame_length = m_axis_tdata[14:5];
        got.received_check = m_axis_tdata[30:15];
        got.computed_check = m_axis_tdata[46:31];
        n_frames++;
        if (frames_expected.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", got);
        end else begin
          want = frames_expected.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch (exp/act): kind %0d/%0d verdict %0d/%0d match %0d/%0d",
                       want.frame_kind, got.frame_kind, want.verdict, got.verdict,
                       want.type_matches, got.type_matches);
              $display("  len %0d/%0d rcv %h/%h cmp %h/%h",
                       want.frame_length, got.frame_length, want.received_check,
                       got.received_check, want.computed_check, got.computed_check);
            end
          end
        end
      end
      m_axis_tready <= quiet || ($urandom_range(0, 99) >= 30);
      if (cycles > CycleLimit) begin
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic drain();
    while (bytes_pending.size() != 0 || s_axis_tvalid || frames_expected.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [23:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegLimit: lim_q = val[9:0];
      RegClass: cls_q = val[7:0];
      RegId:    id_q = val[7:0];
      default:  stype_q = val;
    endcase
    @(posedge clk_i);
  endtask

  initial begin
    lim_q = LimitReset; cls_q = ClassReset; id_q = IdReset; stype_q = TypeReset;
    mode_q = 0; sync_q = 0; bcnt_q = 0; btgt_q = 0; hdr_q = 0; fsum_q = 0; last2_q = 0;
    text_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: sentences, sync corner cases, binary extremes
    put_sentence(1, 2, 1);
    put_sentence(0, 2, 1);
    put_sentence(1, 0, 0);
    put_byte(ChDollar); put_byte(ChDollar);
    put_byte(Sync1); put_byte(ChDollar); put_byte(Sync1); put_byte(Sync1);
    put_byte(ChStar); put_byte("g"); put_byte(8'hFF); put_byte(8'h00);
    put_binary(cls_q, id_q, 1, 1);
    put_binary(cls_q, id_q, 0, 1);
    put_binary(cls_q, id_q, 121, 1);
    put_binary(8'hFF, id_q, 4, 1);
    put_binary(cls_q, id_q, 120, 0);
    drain();

    // long text with no close saturates the length counter
    put_byte("x");
    repeat (1100) put_byte(8'($urandom_range(48, 122)));
    put_byte(ChDollar);
    drain();

    write_reg(RegLimit, 24'd1023);
    write_reg(RegClass, 24'hFF);
    write_reg(RegId, 24'h00);
    write_reg(RegType, 24'hFFFFFF);
    put_binary(8'hFF, 8'h00, 1023, 1);
    random_block(130);
    drain();

    write_reg(RegLimit, 24'd1);
    write_reg(RegClass, 24'h00);
    write_reg(RegId, 24'hFF);
    write_reg(RegType, 24'h000000);
    random_block(130);
    drain();

    write_reg(RegLimit, 24'd16);
    write_reg(RegClass, 24'h01);
    write_reg(RegId, 24'h3C);
    write_reg(RegType, "RMC");
    quiet = 1;
    random_block(70);
    drain();
    quiet = 0;
    random_block(70);
    put_byte(ChDollar);
    drain();

    $display("%0d bytes sent, %0d frames checked over four register settings",
             n_bytes, n_frames);
    if (errors == 0 && frames_expected.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/gnfc_pkg.sv
hw/rtl/gnfc_front.sv
hw/rtl/gnfc_queue.sv
hw/rtl/gnfc_back.sv
hw/rtl/gnss_nmea_ubx_frame_checker.sv
dv/gnss_nmea_ubx_frame_checker_tb.sv
